[design/assert_macros.svh]
// Assertion macros shared by the accumulator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside reset.
`define BMSA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Property whose consequent must hold in the cycle after its trigger.
`define BMSA_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

[design/bmsa_pkg.sv]
// Package: constants, codes and types of the binned mean/stddev accumulator.
`timescale 1ns / 1ps
package bmsa_pkg;

  localparam int MAX_BINS_DEF   = 16;
  localparam int COUNT_BITS_DEF = 16;

  localparam int OP_W      = 2;
  localparam int TAG_W     = 12;
  localparam int TOT_W     = 10;
  localparam int STATUS_W  = 3;
  localparam int OUT_CNT_W = 16;
  localparam int Q8_W      = 18;

  localparam logic [Q8_W-1:0] Q8_MAX = 18'd261888;

  localparam logic [OP_W-1:0] OP_ADD     = 2'd0;
  localparam logic [OP_W-1:0] OP_ANALYSE = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR   = 2'd2;

  localparam logic [STATUS_W-1:0] ST_ADDED   = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NEW     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_SAT     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_BIN     = 3'd4;
  localparam logic [STATUS_W-1:0] ST_NODATA  = 3'd5;
  localparam logic [STATUS_W-1:0] ST_CLEARED = 3'd6;

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_CHECK, S_NEW, S_UPD, S_ARD, S_ALOAD, S_AWAIT, S_AEMIT,
    S_NODATA, S_CLEAR
  } state_t;

  typedef enum logic [2:0] {
    P_IDLE, P_MULA, P_MULB, P_ROOT, P_DIVQ, P_DIVM, P_DONE
  } phase_t;

  typedef struct packed {
    logic            busy;
    logic            done;
    logic [Q8_W-1:0] mean;
    logic [Q8_W-1:0] sd;
  } stat_res_t;

endpackage

[design/bmsa_stat.sv]
// Serial statistics unit: mean and standard deviation of one bin on one shared adder.
`timescale 1ns / 1ps
module bmsa_stat #(
  parameter int COUNT_BITS = bmsa_pkg::COUNT_BITS_DEF
) (
  input  logic                                          clk,
  input  logic                                          rst,
  input  logic                                          start,
  input  logic [COUNT_BITS-1:0]                         n,
  input  logic [COUNT_BITS+bmsa_pkg::TOT_W-1:0]         s,
  input  logic [COUNT_BITS+2*bmsa_pkg::TOT_W-1:0]       sq,
  output bmsa_pkg::stat_res_t                           res
);
  import bmsa_pkg::*;

  localparam int CB  = COUNT_BITS;
  localparam int SW  = CB + TOT_W;
  localparam int QW  = CB + 2 * TOT_W;
  localparam int DW  = 2 * CB + 2 * TOT_W;
  localparam int AW  = DW + 1;
  localparam int YW  = DW + 18;
  localparam int RW  = YW / 2;
  localparam int MW  = SW + 10;
  localparam int ITW = $clog2(MW + 1);

  phase_t phase, phase_next;

  logic [AW-1:0]  acc;
  logic [AW-1:0]  mc;
  logic [SW-1:0]  mp;
  logic [YW-1:0]  ysh;
  logic [RW-1:0]  root;
  logic [CB-1:0]  n_r;
  logic [SW-1:0]  s_r;
  logic [ITW-1:0] cnt;

  logic [AW-1:0]  opa, opb;
  logic           sub;
  logic [AW:0]    sum;
  logic           neg;
  logic           last_iter;
  logic [RW:0]    sd_half;

  // shared adder operand selection
  always_comb begin
    opa = acc;
    opb = mc;
    sub = 1'b0;
    case (phase)
      P_MULA: begin
        opa = acc;
        opb = mc;
        sub = 1'b0;
      end
      P_MULB: begin
        opa = acc;
        opb = mc;
        sub = 1'b1;
      end
      P_ROOT: begin
        opa = {acc[AW-3:0], ysh[YW-1:YW-2]};
        opb = AW'({root, 2'b01});
        sub = 1'b1;
      end
      P_DIVQ: begin
        opa = {acc[AW-2:0], root[RW-1]};
        opb = AW'(n_r);
        sub = 1'b1;
      end
      P_DIVM: begin
        opa = {acc[AW-2:0], ysh[MW-1]};
        opb = AW'({n_r, 1'b0});
        sub = 1'b1;
      end
      default: begin
        opa = acc;
        opb = mc;
        sub = 1'b0;
      end
    endcase
  end

  assign sum = {1'b0, opa} + (sub ? ~{1'b0, opb} : {1'b0, opb}) + (AW+1)'(sub);
  assign neg = sum[AW];
  assign last_iter = (cnt == ITW'(1));

  always_comb begin
    phase_next = phase;
    case (phase)
      P_IDLE:  if (start) phase_next = P_MULA;
      P_MULA:  if (last_iter) phase_next = P_MULB;
      P_MULB:  if (last_iter) phase_next = P_ROOT;
      P_ROOT:  if (last_iter) phase_next = P_DIVQ;
      P_DIVQ:  if (last_iter) phase_next = P_DIVM;
      P_DIVM:  if (last_iter) phase_next = P_DONE;
      P_DONE:  phase_next = P_IDLE;
      default: phase_next = P_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= P_IDLE;
    end else begin
      phase <= phase_next;
    end
  end

  always_ff @(posedge clk) begin
    cnt <= cnt - ITW'(1);
    case (phase)
      P_IDLE: begin
        acc <= '0;
        mc  <= AW'(sq);
        mp  <= SW'(n);
        n_r <= n;
        s_r <= s;
        cnt <= ITW'(CB);
      end
      P_MULA: begin
        if (mp[0]) acc <= sum[AW-1:0];
        mc <= {mc[AW-2:0], 1'b0};
        mp <= mp >> 1;
        if (last_iter) begin
          mc  <= AW'(s_r);
          mp  <= s_r;
          cnt <= ITW'(SW);
        end
      end
      P_MULB: begin
        if (mp[0]) acc <= sum[AW-1:0];
        mc <= {mc[AW-2:0], 1'b0};
        mp <= mp >> 1;
        if (last_iter) begin
          // clamp a negative difference to zero, then scale by 2^18
          if (mp[0]) begin
            ysh <= sum[AW-1] ? '0 : {sum[DW-1:0], 18'd0};
          end else begin
            ysh <= acc[AW-1] ? '0 : {acc[DW-1:0], 18'd0};
          end
          acc  <= '0;
          root <= '0;
          cnt  <= ITW'(RW);
        end
      end
      P_ROOT: begin
        if (!neg) begin
          acc  <= sum[AW-1:0];
          root <= {root[RW-2:0], 1'b1};
        end else begin
          acc  <= opa;
          root <= {root[RW-2:0], 1'b0};
        end
        ysh <= {ysh[YW-3:0], 2'b00};
        // drop the root remainder before the division starts
        if (last_iter) begin
          acc <= '0;
          cnt <= ITW'(RW);
        end
      end
      P_DIVQ: begin
        // quotient bits enter from the bottom as dividend bits leave the top
        acc  <= neg ? opa : sum[AW-1:0];
        root <= {root[RW-2:0], ~neg};
        if (last_iter) begin
          acc <= '0;
          ysh <= YW'(MW'({s_r, 9'd0}) + MW'(n_r));
          cnt <= ITW'(MW);
        end
      end
      P_DIVM: begin
        acc <= neg ? opa : sum[AW-1:0];
        ysh <= {ysh[YW-2:0], ~neg};
      end
      default: ;
    endcase
  end

  assign sd_half = ((RW+1)'(root) + (RW+1)'(1)) >> 1;

  always_comb begin
    res.busy = (phase != P_IDLE);
    res.done = (phase == P_DONE);
    res.mean = (ysh[MW-1:0] > MW'(Q8_MAX)) ? Q8_MAX : ysh[Q8_W-1:0];
    res.sd   = (sd_half > (RW+1)'(Q8_MAX)) ? Q8_MAX : sd_half[Q8_W-1:0];
  end

endmodule

[design/binned_mean_stddev_accumulator_unit.sv]
// Top level: bin table, add/analyse/clear sequencer and output register.
// Add: one registered table read and one compare per bin compared.
// Analyse: per bin, a table read, a start of the shared serial unit, a wait for its result and an emit.
// Clear and no-data emit a single result; unused codes give none. Input stalls while an item is in work.
// Synchronous reset empties the table (bin count zero); table contents are not cleared.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module binned_mean_stddev_accumulator_unit #(
  parameter int MAX_BINS   = bmsa_pkg::MAX_BINS_DEF,
  parameter int COUNT_BITS = bmsa_pkg::COUNT_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [bmsa_pkg::OP_W-1:0]          operation,
  input  logic [bmsa_pkg::TAG_W-1:0]         pulse_mv,
  input  logic [bmsa_pkg::TOT_W-1:0]         tot_sample,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [bmsa_pkg::STATUS_W-1:0]      status,
  output logic [bmsa_pkg::TAG_W-1:0]         bin_pulse_mv,
  output logic [bmsa_pkg::OUT_CNT_W-1:0]     bin_count,
  output logic [bmsa_pkg::Q8_W-1:0]          mean_q8,
  output logic [bmsa_pkg::Q8_W-1:0]          stddev_q8,
  output logic                               last
);
  import bmsa_pkg::*;

  localparam int CB  = COUNT_BITS;
  localparam int SW  = CB + TOT_W;
  localparam int QW  = CB + 2 * TOT_W;
  localparam int IW  = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
  localparam int UW  = $clog2(MAX_BINS + 1);
  localparam int CXW = (CB > OUT_CNT_W) ? CB : OUT_CNT_W;
  localparam logic [CB-1:0] CMAX = {CB{1'b1}};

  state_t state, state_next;

  logic [TAG_W-1:0] tags [MAX_BINS];
  logic [CB-1:0]    counts [MAX_BINS];
  logic [SW-1:0]    sums [MAX_BINS];
  logic [QW-1:0]    sqs [MAX_BINS];

  logic [TAG_W-1:0]   rd_tag;
  logic [CB-1:0]      rd_count;
  logic [SW-1:0]      rd_sum;
  logic [QW-1:0]      rd_sq;

  logic [UW-1:0]      used;
  logic [UW-1:0]      idx;
  logic [TAG_W-1:0]   mv;
  logic [TOT_W-1:0]   tot;
  logic [2*TOT_W-1:0] tot_sq;
  logic [Q8_W-1:0]    mean_r, sd_r;

  logic               out_free;
  logic               accept;
  logic               idx_last;
  logic               full;

  logic               emit, we, stat_start;
  logic [IW-1:0]      wr_addr;
  logic [STATUS_W-1:0] r_status;
  logic [TAG_W-1:0]   r_tag;
  logic [CB-1:0]      r_count;
  logic [Q8_W-1:0]    r_mean, r_sd;
  logic               r_last;
  logic [CXW-1:0]     cnt_x;

  stat_res_t stat_res;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign idx_last = ((UW+1)'(idx) + (UW+1)'(1)) == (UW+1)'(used);
  assign full     = (used == UW'(MAX_BINS));

  bmsa_stat #(
    .COUNT_BITS(COUNT_BITS)
  ) u_stat (
    .clk  (clk),
    .rst  (rst),
    .start(stat_start),
    .n    (rd_count),
    .s    (rd_sum),
    .sq   (rd_sq),
    .res  (stat_res)
  );

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          case (operation)
            OP_ADD:     state_next = (used == '0) ? S_NEW : S_SCAN;
            OP_ANALYSE: state_next = (used == '0) ? S_NODATA : S_ARD;
            OP_CLEAR:   state_next = S_CLEAR;
            default:    state_next = S_IDLE;
          endcase
        end
      end
      S_SCAN:  state_next = S_CHECK;
      S_CHECK: begin
        if (rd_tag == mv) state_next = S_UPD;
        else if (idx_last) state_next = S_NEW;
        else state_next = S_SCAN;
      end
      S_NEW, S_UPD, S_NODATA, S_CLEAR: if (out_free) state_next = S_IDLE;
      S_ARD:   state_next = S_ALOAD;
      S_ALOAD: state_next = S_AWAIT;
      S_AWAIT: if (stat_res.done) state_next = S_AEMIT;
      S_AEMIT: if (out_free) state_next = idx_last ? S_IDLE : S_ARD;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    emit       = 1'b0;
    we         = 1'b0;
    stat_start = 1'b0;
    wr_addr    = idx[IW-1:0];
    r_status   = ST_ADDED;
    r_tag      = mv;
    r_count    = '0;
    r_mean     = '0;
    r_sd       = '0;
    r_last     = 1'b1;
    case (state)
      S_NEW: begin
        emit    = out_free;
        wr_addr = used[IW-1:0];
        if (full) begin
          r_status = ST_FULL;
        end else begin
          r_status = ST_NEW;
          r_count  = CB'(1);
          we       = out_free;
        end
      end
      S_UPD: begin
        emit = out_free;
        if (rd_count == CMAX) begin
          r_status = ST_SAT;
          r_count  = rd_count;
        end else begin
          r_status = ST_ADDED;
          r_count  = rd_count + CB'(1);
          we       = out_free;
        end
      end
      S_ALOAD: stat_start = 1'b1;
      S_AEMIT: begin
        emit     = out_free;
        r_status = ST_BIN;
        r_tag    = rd_tag;
        r_count  = rd_count;
        r_mean   = (rd_count == '0) ? '0 : mean_r;
        r_sd     = (rd_count == '0) ? '0 : sd_r;
        r_last   = idx_last;
      end
      S_NODATA: begin
        emit     = out_free;
        r_status = ST_NODATA;
        r_tag    = '0;
      end
      S_CLEAR: begin
        emit     = out_free;
        r_status = ST_CLEARED;
        r_tag    = '0;
      end
      default: ;
    endcase
  end

  assign cnt_x = CXW'(r_count);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      used      <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (emit) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
      if (state == S_NEW && we) used <= used + UW'(1);
      if (state == S_CLEAR && out_free) used <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mv     <= pulse_mv;
      tot    <= tot_sample;
      tot_sq <= (2*TOT_W)'(tot_sample) * (2*TOT_W)'(tot_sample);
      idx    <= '0;
    end
    if (state == S_CHECK && rd_tag != mv) idx <= idx + UW'(1);
    if (state == S_AEMIT && out_free) idx <= idx + UW'(1);
    if (state == S_AWAIT && stat_res.done) begin
      mean_r <= stat_res.mean;
      sd_r   <= stat_res.sd;
    end
    if (emit) begin
      status       <= r_status;
      bin_pulse_mv <= r_tag;
      bin_count    <= (cnt_x > CXW'(16'hFFFF)) ? 16'hFFFF : cnt_x[OUT_CNT_W-1:0];
      mean_q8      <= r_mean;
      stddev_q8    <= r_sd;
      last         <= r_last;
    end
  end

  // bin table: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      tags[wr_addr] <= mv;
      if (state == S_NEW) begin
        counts[wr_addr] <= CB'(1);
        sums[wr_addr]   <= SW'(tot);
        sqs[wr_addr]    <= QW'(tot_sq);
      end else begin
        counts[wr_addr] <= rd_count + CB'(1);
        sums[wr_addr]   <= rd_sum + SW'(tot);
        sqs[wr_addr]    <= rd_sq + QW'(tot_sq);
      end
    end
    rd_tag   <= tags[idx[IW-1:0]];
    rd_count <= counts[idx[IW-1:0]];
    rd_sum   <= sums[idx[IW-1:0]];
    rd_sq    <= sqs[idx[IW-1:0]];
  end

  `BMSA_ASSERT(a_used_range, used <= UW'(MAX_BINS), "bin count beyond table size")
  `BMSA_ASSERT(a_accept_idle, accept |-> !stat_res.busy, "item taken while statistics busy")
  `BMSA_ASSERT(a_single_last, (out_valid && status != ST_BIN) |-> last, "single result without last")
  `BMSA_ASSERT_NEXT(a_stat_done, stat_res.done, state == S_AEMIT, "statistics result not emitted")

endmodule
